/* design/dtl_pkg.sv */
// ----------------------------------------------------------------------------
// dtl_pkg
// Shared types and constants for the double-byte text layout cursor.
// ----------------------------------------------------------------------------
`default_nettype none

package dtl_pkg;

  localparam logic [7:0] TEXT_END     = 8'h00;
  localparam logic [7:0] NEWLINE      = 8'h0A;
  localparam logic [7:0] GB_FIRST     = 8'hA1;
  localparam logic [7:0] GB_LAST      = 8'hFE;
  localparam int         GB_ROW_LEN   = 94;
  localparam int         GLYPH_BYTES  = 28;
  localparam logic [3:0] GLYPH_STEP   = 4'd14;
  localparam logic [3:0] ASCII_STEP   = 4'd7;
  localparam logic [3:0] LINE_STEP    = 4'd13;
  localparam logic [3:0] ASCII_Y_OFS  = 4'd4;
  localparam logic [7:0] BOTTOM_RESET = 8'd63;
  localparam logic [9:0] X_MAX        = 10'd1023;
  localparam logic [6:0] Y_MAX        = 7'd127;

  localparam logic [2:0] MODE_NORMAL       = 3'd0;
  localparam logic [2:0] MODE_REVERSE      = 3'd1;
  localparam logic [2:0] MODE_VERTICAL     = 3'd3;
  localparam logic [2:0] MODE_VERT_REVERSE = 3'd4;

  localparam logic KIND_GLYPH = 1'b0;
  localparam logic KIND_ASCII = 1'b1;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       start_of_text;
    logic [6:0] start_x;
    logic [5:0] start_y;
    logic [2:0] draw_mode;
  } in_item_t;

  typedef struct packed {
    logic        draw_kind;
    logic [9:0]  pos_x;
    logic [6:0]  pos_y;
    logic [17:0] font_offset;
    logic [6:0]  ascii_code;
    logic        invert;
    logic        shift_glyph_right;
  } cmd_t;

endpackage

`default_nettype wire

/* design/dtl_glyph_offset.sv */
// ----------------------------------------------------------------------------
// dtl_glyph_offset
// Byte offset of a 28-byte glyph bitmap from a two-byte code; zero when
// either byte lies outside the code range.
// ----------------------------------------------------------------------------
`default_nettype none

module dtl_glyph_offset (
  input  wire logic [7:0]  lead,
  input  wire logic [7:0]  trail,
  output logic      [17:0] font_offset
);
  import dtl_pkg::*;

  logic        in_range;
  logic [6:0]  row_full;
  logic [6:0]  col_full;
  logic [13:0] glyph_index;

  always_comb begin
    in_range    = (lead >= GB_FIRST) && (lead <= GB_LAST) &&
                  (trail >= GB_FIRST) && (trail <= GB_LAST);
    row_full    = 7'(lead - GB_FIRST);
    col_full    = 7'(trail - GB_FIRST);
    glyph_index = 14'(row_full) * 14'(GB_ROW_LEN) + 14'(col_full);
    font_offset = in_range ? 18'(glyph_index) * 18'(GLYPH_BYTES) : '0;
  end

endmodule

`default_nettype wire

/* design/dtl_layout_stage.sv */
// ----------------------------------------------------------------------------
// dtl_layout_stage
// Cursor state, byte decode and the result register. One buffered byte is
// consumed in each cycle in which the result register can take a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module dtl_layout_stage (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            item_valid,
  input  wire dtl_pkg::in_item_t item,
  input  wire logic [7:0]      bottom_limit,
  input  wire logic            out_ready,
  output logic                 stage_go,
  output logic                 out_valid,
  output dtl_pkg::cmd_t        cmd
);
  import dtl_pkg::*;

  logic [9:0] cursor_x, cursor_x_next;
  logic [6:0] cursor_y, cursor_y_next;
  logic [6:0] line_start_x, line_start_x_next;
  logic [7:0] held_lead_byte, held_lead_byte_next;
  logic       lead_pending, lead_pending_next;
  logic       text_finished, text_finished_next;
  logic [2:0] current_mode, current_mode_next;
  logic       emit;
  cmd_t       cmd_next;

  logic [9:0]  cx0;
  logic [6:0]  cy0;
  logic        lead0;
  logic        fin0;
  logic        vertical;
  logic [3:0]  step;
  logic [10:0] x_sum;
  logic [7:0]  y_sum;
  logic [9:0]  x_adv;
  logic [6:0]  y_adv;
  logic [7:0]  y_line;
  logic [7:0]  y_ascii;
  logic [6:0]  y_check;
  logic [17:0] glyph_ofs;

  dtl_glyph_offset u_offset (
    .lead        (held_lead_byte),
    .trail       (item.text_byte),
    .font_offset (glyph_ofs)
  );

  always_comb begin
    stage_go = !out_valid || out_ready;

    cx0   = item.start_of_text ? 10'(item.start_x) : cursor_x;
    cy0   = item.start_of_text ? 7'(item.start_y) : cursor_y;
    lead0 = item.start_of_text ? 1'b0 : lead_pending;
    fin0  = item.start_of_text ? 1'b0 : text_finished;

    current_mode_next   = item.start_of_text ? item.draw_mode : current_mode;
    line_start_x_next   = item.start_of_text ? item.start_x : line_start_x;
    held_lead_byte_next = item.start_of_text ? 8'h00 : held_lead_byte;
    lead_pending_next   = lead0;
    text_finished_next  = fin0;
    cursor_x_next       = cx0;
    cursor_y_next       = cy0;

    vertical = (current_mode_next == MODE_VERTICAL) ||
               (current_mode_next == MODE_VERT_REVERSE);
    step     = lead0 ? GLYPH_STEP : ASCII_STEP;
    x_sum    = {1'b0, cx0} + 11'(step);
    y_sum    = {1'b0, cy0} + 8'(step);
    x_adv    = x_sum[10] ? X_MAX : x_sum[9:0];
    y_adv    = y_sum[7] ? Y_MAX : y_sum[6:0];
    y_line   = {1'b0, cy0} + 8'(LINE_STEP);
    y_ascii  = {1'b0, cy0} + 8'(ASCII_Y_OFS);

    emit     = 1'b0;
    cmd_next = '0;
    cmd_next.pos_x = cx0;

    if (!fin0) begin
      if (item.text_byte == TEXT_END) begin
        lead_pending_next  = 1'b0;
        text_finished_next = 1'b1;
      end else if (lead0) begin
        emit                       = 1'b1;
        lead_pending_next          = 1'b0;
        cmd_next.draw_kind         = KIND_GLYPH;
        cmd_next.pos_y             = cy0;
        cmd_next.font_offset       = glyph_ofs;
        cmd_next.invert            = (current_mode_next == MODE_REVERSE) ||
                                     (current_mode_next == MODE_VERT_REVERSE);
        cmd_next.shift_glyph_right = (current_mode_next == MODE_VERT_REVERSE);
        if (vertical) begin
          cursor_y_next = y_adv;
        end else begin
          cursor_x_next = x_adv;
        end
      end else if (item.text_byte[7]) begin
        held_lead_byte_next = item.text_byte;
        lead_pending_next   = 1'b1;
      end else if (item.text_byte == NEWLINE) begin
        cursor_x_next = 10'(line_start_x_next);
        cursor_y_next = y_line[7] ? Y_MAX : y_line[6:0];
      end else begin
        emit                = 1'b1;
        cmd_next.draw_kind  = KIND_ASCII;
        cmd_next.pos_y      = y_ascii[7] ? Y_MAX : y_ascii[6:0];
        cmd_next.ascii_code = item.text_byte[6:0];
        cmd_next.invert     = (current_mode_next != MODE_NORMAL);
        if (vertical) begin
          cursor_y_next = y_adv;
        end else begin
          cursor_x_next = x_adv;
        end
      end
    end

    y_check = cursor_y_next;
    if (!fin0 && (item.text_byte != TEXT_END) &&
        (lead0 || !item.text_byte[7]) &&
        ((8'(y_check) + 8'(GLYPH_STEP)) >= bottom_limit)) begin
      text_finished_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_x       <= '0;
      cursor_y       <= '0;
      line_start_x   <= '0;
      held_lead_byte <= '0;
      lead_pending   <= 1'b0;
      text_finished  <= 1'b1;
      current_mode   <= MODE_NORMAL;
      out_valid      <= 1'b0;
    end else begin
      if (item_valid && stage_go) begin
        cursor_x       <= cursor_x_next;
        cursor_y       <= cursor_y_next;
        line_start_x   <= line_start_x_next;
        held_lead_byte <= held_lead_byte_next;
        lead_pending   <= lead_pending_next;
        text_finished  <= text_finished_next;
        current_mode   <= current_mode_next;
      end
      if (stage_go) begin
        out_valid <= item_valid && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (item_valid && stage_go && emit) begin
      cmd <= cmd_next;
    end
  end

endmodule

`default_nettype wire

/* design/dbcs_text_layout_cursor_core.sv */
// ----------------------------------------------------------------------------
// dbcs_text_layout_cursor_core
// Lays out a byte stream of ASCII and two-byte GB2312 codes as draw commands.
// Path: a byte is held in the input buffer, then its command is registered in
// the result register and offered there until out_ready takes it.
// Throughput: one byte per cycle unless out_ready stalls; the single layout
// stage updates the cursor and loads the result register in the same cycle.
// Reset: synchronous; cursor and mode clear, the text is finished until a
// start byte, and bottom_limit returns to 63.
// ----------------------------------------------------------------------------
`default_nettype none

module dbcs_text_layout_cursor_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_valid,
  output logic             cfg_ready,
  input  wire logic [7:0]  cfg_data,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  text_byte,
  input  wire logic        start_of_text,
  input  wire logic [6:0]  start_x,
  input  wire logic [5:0]  start_y,
  input  wire logic [2:0]  draw_mode,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic             draw_kind,
  output logic [9:0]       pos_x,
  output logic [6:0]       pos_y,
  output logic [17:0]      font_offset,
  output logic [6:0]       ascii_code,
  output logic             invert,
  output logic             shift_glyph_right
);
  import dtl_pkg::*;

  logic [7:0] bottom_limit;
  logic       buf_valid;
  in_item_t   buf_item;
  logic       stage_go;
  cmd_t       cmd;

  assign cfg_ready = 1'b1;
  assign in_ready  = !buf_valid || stage_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      bottom_limit <= BOTTOM_RESET;
      buf_valid    <= 1'b0;
    end else begin
      if (cfg_valid) begin
        bottom_limit <= cfg_data;
      end
      if (in_ready) begin
        buf_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      buf_item <= '{text_byte: text_byte, start_of_text: start_of_text,
                    start_x: start_x, start_y: start_y, draw_mode: draw_mode};
    end
  end

  dtl_layout_stage u_stage (
    .clk          (clk),
    .rst          (rst),
    .item_valid   (buf_valid),
    .item         (buf_item),
    .bottom_limit (bottom_limit),
    .out_ready    (out_ready),
    .stage_go     (stage_go),
    .out_valid    (out_valid),
    .cmd          (cmd)
  );

  assign draw_kind         = cmd.draw_kind;
  assign pos_x             = cmd.pos_x;
  assign pos_y             = cmd.pos_y;
  assign font_offset       = cmd.font_offset;
  assign ascii_code        = cmd.ascii_code;
  assign invert            = cmd.invert;
  assign shift_glyph_right = cmd.shift_glyph_right;

endmodule

`default_nettype wire

/* design/dtl_checker.sv */
// ----------------------------------------------------------------------------
// dtl_checker
// Port-level checks on the draw command stream of the layout cursor.
// ----------------------------------------------------------------------------
`default_nettype none

module dtl_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        draw_kind,
  input wire logic [9:0]  pos_x,
  input wire logic [6:0]  pos_y,
  input wire logic [17:0] font_offset,
  input wire logic [6:0]  ascii_code,
  input wire logic        invert,
  input wire logic        shift_glyph_right
);
  import dtl_pkg::*;

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(pos_x) && $stable(pos_y) &&
      $stable(font_offset) && $stable(ascii_code) && $stable(draw_kind))
    else $error("dtl: stalled beat changed");

  a_ascii: assert property (@(posedge clk) disable iff (rst)
    out_valid && (draw_kind == KIND_ASCII) |->
      (font_offset == '0) && !shift_glyph_right && (pos_y >= 7'(ASCII_Y_OFS)))
    else $error("dtl: malformed character command");

  a_glyph: assert property (@(posedge clk) disable iff (rst)
    out_valid && (draw_kind == KIND_GLYPH) |-> (ascii_code == '0))
    else $error("dtl: glyph command carries a character code");

  a_shift: assert property (@(posedge clk) disable iff (rst)
    out_valid && shift_glyph_right |-> invert)
    else $error("dtl: shifted glyph not inverted");

  a_reset: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("dtl: beat offered straight after reset");

endmodule

bind dbcs_text_layout_cursor_core dtl_checker u_dtl_checker (.*);

`default_nettype wire
